/* rtl/b2da_pkg.sv */
`default_nettype none
// ============================================================================
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ============================================================================
package b2da_pkg;

    // Width of the binary operand
    localparam int VALUE_BITS  = 32;
    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int DIGIT_COUNT = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W   = $clog2(DIGIT_COUNT);
    localparam int CHAR_W      = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Input beat
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_signed;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_out_beat;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DABBLE,
        S_SIGN,
        S_DIGITS
    } t_state;

    // Control broadcast to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction, then shift one bit in
        logic shift;   // take the lower neighbor's digit
    } t_cell_ctl;

endpackage
`default_nettype wire

/* rtl/b2da_cell.sv */
`default_nettype none
// ============================================================================
// b2da_cell
// One BCD digit of the double-dabble chain. Shifts a bit up to its upper
// neighbor while converting, and passes whole digits up while emitting.
// ============================================================================
module b2da_cell (
    input  wire logic                 i_clk,
    input  wire b2da_pkg::t_cell_ctl  i_ctl,
    input  wire logic                 i_carry,
    input  wire logic [3:0]           i_digit,
    output logic                      o_carry,
    output logic [3:0]                o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add 3 when the digit would overflow past 9 on the next doubling
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[2:0], i_carry};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
`default_nettype wire

/* rtl/binary_to_decimal_ascii.sv */
`default_nettype none
// ============================================================================
// binary_to_decimal_ascii
// Converts a 32-bit value, signed or unsigned, to decimal ASCII text, one
// character per output beat, most significant digit first.
// ============================================================================
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------
//  input   | i_in_valid  | o_in_stall   | i_in  (value, is_signed)
//  output  | o_out_valid | i_out_stall  | o_out (char_code, last_char)
//
//  An item is loaded, shifted bit by bit through the chain of ten digit
//  cells, then emitted digit by digit (suppressed leading zeros are stepped
//  past without output), preceded by a minus sign when the value is negative.
//  One item at a time; o_in_stall is high from accept to the last character.
//  Output stall holds the output register and pauses the digit sequence.
//  Reset (synchronous, active low) returns to idle with no output pending.
// ============================================================================
module binary_to_decimal_ascii (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire b2da_pkg::t_in_beat  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output b2da_pkg::t_out_beat      o_out
);

    localparam int ND = b2da_pkg::DIGIT_COUNT;
    localparam int VB = b2da_pkg::VALUE_BITS;

    b2da_pkg::t_state    r_state, n_state;
    logic [VB-1:0]       r_bin, n_bin;
    logic                r_neg, n_neg;
    logic [b2da_pkg::BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [b2da_pkg::DIG_CNT_W-1:0] r_dig_cnt, n_dig_cnt;
    logic                r_started, n_started;
    logic                r_out_valid, n_out_valid;
    b2da_pkg::t_out_beat r_out, n_out;

    b2da_pkg::t_cell_ctl w_ctl;
    logic [ND:0]         w_carry;
    logic [3:0]          w_dig [ND+1];
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_skip;
    logic                w_in_neg;
    logic [VB-1:0]       w_mag;
    logic [3:0]          w_top;

    // Handshake
    assign o_in_stall = (r_state != b2da_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == b2da_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Magnitude of the incoming value
    assign w_in_neg = i_in.is_signed && i_in.value[VB-1];
    assign w_mag    = w_in_neg ? (~i_in.value + VB'(1)) : i_in.value;

    // Digit cell chain: carries go up while converting, digits go up while emitting
    assign w_carry[0] = r_bin[VB-1];
    assign w_dig[0]   = 4'd0;
    assign w_top      = w_dig[ND];

    for (genvar k = 0; k < ND; k++) begin : g_cell
        b2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_carry (w_carry[k]),
            .i_digit (w_dig[k]),
            .o_carry (w_carry[k+1]),
            .o_digit (w_dig[k+1])
        );
    end

    // Leading zero suppression
    assign w_skip = !r_started && (w_top == 4'd0) && (r_dig_cnt != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            b2da_pkg::S_IDLE: begin
                if (w_in_acc) n_state = b2da_pkg::S_DABBLE;
            end
            b2da_pkg::S_DABBLE: begin
                if (r_bit_cnt == '0) begin
                    n_state = r_neg ? b2da_pkg::S_SIGN : b2da_pkg::S_DIGITS;
                end
            end
            b2da_pkg::S_SIGN: begin
                if (w_out_free) n_state = b2da_pkg::S_DIGITS;
            end
            b2da_pkg::S_DIGITS: begin
                if (!w_skip && w_out_free && (r_dig_cnt == '0)) begin
                    n_state = b2da_pkg::S_IDLE;
                end
            end
            default: n_state = b2da_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        w_ctl       = '0;
        n_bin       = r_bin;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_started   = r_started;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            b2da_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_ctl.clear = 1'b1;
                    n_bin       = w_mag;
                    n_neg       = w_in_neg;
                    n_bit_cnt   = b2da_pkg::BIT_CNT_W'(VB - 1);
                end
            end
            b2da_pkg::S_DABBLE: begin
                w_ctl.dabble = 1'b1;
                n_bin        = {r_bin[VB-2:0], 1'b0};
                n_bit_cnt    = r_bit_cnt - b2da_pkg::BIT_CNT_W'(1);
                n_dig_cnt    = b2da_pkg::DIG_CNT_W'(ND - 1);
                n_started    = 1'b0;
            end
            b2da_pkg::S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.char_code = b2da_pkg::CHAR_MINUS;
                    n_out.last_char = 1'b0;
                end
            end
            b2da_pkg::S_DIGITS: begin
                if (w_skip) begin
                    w_ctl.shift = 1'b1;
                    n_dig_cnt   = r_dig_cnt - b2da_pkg::DIG_CNT_W'(1);
                end else if (w_out_free) begin
                    w_ctl.shift     = 1'b1;
                    n_started       = 1'b1;
                    n_dig_cnt       = r_dig_cnt - b2da_pkg::DIG_CNT_W'(1);
                    n_out_valid     = 1'b1;
                    n_out.char_code = b2da_pkg::CHAR_ZERO + {2'b00, w_top};
                    n_out.last_char = (r_dig_cnt == '0);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2da_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_neg     <= n_neg;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_started <= n_started;
        r_out     <= n_out;
    end

    // The top cell never overflows: the magnitude always fits in the digit chain
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::S_DABBLE) |-> !w_carry[ND])
        else $error("digit chain overflow");

    // Whatever waits at the output while idle is the final character
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::S_IDLE && r_out_valid) |-> r_out.last_char)
        else $error("idle with a non-final character pending");

    // Conversion ends after the last bit shift
    a_dabble_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2da_pkg::S_DABBLE && r_bit_cnt == '0) |=>
        (r_state == b2da_pkg::S_SIGN || r_state == b2da_pkg::S_DIGITS))
        else $error("conversion did not end on time");

endmodule
`default_nettype wire

/* test/binary_to_decimal_ascii_tb.sv */
`default_nettype none
// ============================================================================
// binary_to_decimal_ascii_tb
// Self-checking bench for the binary to decimal ASCII converter. Numbers go in
// on the input channel; a local predictor builds the expected character
// stream for each accepted beat and every output beat is checked in order.
// Both channels see random gaps, and one phase runs with no gaps at all.
// ============================================================================
module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Hang limit; far above the worst-case busy time plus stalls per number
    localparam int LIMIT_CYCLES = 200000;
    localparam int GAP_PCT      = 33;
    localparam int SETTLE_CYCLES = 60;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    b2da_pkg::t_in_beat  in_beat   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    b2da_pkg::t_out_beat out_beat;

    // gaps_on drives random idling on both channels
    bit                  gaps_on     = 1'b1;
    int                  errors      = 0;
    int                  cycle_count = 0;
    b2da_pkg::t_out_beat text_due[$];

    binary_to_decimal_ascii dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decimal text of one number, pushed as expected output beats
    function automatic void predict_text(input b2da_pkg::t_in_beat beat);
        logic [31:0]         mag;
        logic                neg;
        logic [3:0]          digs[10];
        int                  nd;
        b2da_pkg::t_out_beat ch;
        neg = beat.is_signed && beat.value[31];
        mag = neg ? (~beat.value + 32'd1) : beat.value;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0);
        if (neg) begin
            ch.char_code = b2da_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            text_due.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch.char_code = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_W'(digs[i]);
            ch.last_char = (i == 0);
            text_due.push_back(ch);
        end
    endfunction

    // Random value with a spread of magnitudes and the awkward boundaries
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(1, 31);
            2: return $urandom_range(0, 20);
            3: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            4: return 32'd0 - $urandom_range(1, 1000);
            default: return 32'h8000_0000 + $urandom_range(0, 2) - 32'd1;
        endcase
    endfunction

    // Output stall, redrawn every cycle
    always @(negedge clk) begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
    end

    // Scoreboard: predict on input accept, compare on output accept
    always @(posedge clk) begin : score
        b2da_pkg::t_out_beat want;
        cycle_count <= cycle_count + 1;
        if (rst_n) begin
            if (in_valid && !in_stall)
                predict_text(in_beat);
            if (out_valid && !out_stall) begin
                if (text_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected char: expected none, got %0d last %0b",
                             $time, out_beat.char_code, out_beat.last_char);
                end else begin
                    want = text_due.pop_front();
                    if (out_beat.char_code !== want.char_code) begin
                        errors++;
                        $display("%0t: char_code mismatch: expected %0d, got %0d",
                                 $time, want.char_code, out_beat.char_code);
                    end
                    if (out_beat.last_char !== want.last_char) begin
                        errors++;
                        $display("%0t: last_char mismatch: expected %0b, got %0b",
                                 $time, want.last_char, out_beat.last_char);
                    end
                end
            end
        end
    end

    // Hang guard
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // One input beat; returns at the accepting edge
    task automatic send_number(input logic [31:0] v, input logic sgn);
        @(negedge clk);
        while (gaps_on && ($urandom_range(0, 99) < GAP_PCT)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{value: v, is_signed: sgn};
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait for every expected char
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (text_due.size() != 0) @(posedge clk);
    endtask

    // Extremes, zero, sign handling, digit-count boundaries
    task automatic test_directed();
        send_number(32'd0, 1'b0);
        send_number(32'd0, 1'b1);
        send_number(32'd1, 1'b0);
        send_number(32'd1, 1'b1);
        send_number(32'd9, 1'b0);
        send_number(32'd10, 1'b0);
        send_number(32'd99, 1'b1);
        send_number(32'd100, 1'b0);
        send_number(32'd999_999_999, 1'b0);
        send_number(32'd1_000_000_000, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h8000_0000, 1'b0);
        send_number(32'h7FFF_FFFF, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFF6, 1'b1);
        send_number(32'hFFFF_FFF6, 1'b0);
        send_number(32'd4_000_000_000, 1'b0);
        send_number(32'hAAAA_AAAA, 1'b1);
        send_number(32'h5555_5555, 1'b0);
        settle();
    endtask

    // Random numbers, random idling on both sides
    task automatic test_random();
        gaps_on = 1'b1;
        repeat (100) send_number(pick_value(), 1'($urandom_range(0, 1)));
        settle();
    endtask

    // Long stretch with both channels always ready
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (60) send_number(pick_value(), 1'($urandom_range(0, 1)));
        settle();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_back_to_back();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
